// ----- design/lkxc_pkg.sv -----
// Package for the LCG keystream XOR cipher.
// Holds the sequencer state type, register indexes and fixed widths.
// No dependencies; imported by lcg_keystream_xor_cipher.
package lkxc_pkg;

    // Fixed field widths.
    localparam int unsigned WORD_W     = 16;
    localparam int unsigned PROD_W     = 2 * WORD_W;
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned DIV_STEPS  = PROD_W;
    localparam int unsigned STEP_CNT_W = $clog2(DIV_STEPS);

    // Mask applied to the cipher word for a lone trailing byte.
    localparam logic [WORD_W-1:0] BYTE_MASK = 16'h00FF;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_MULTIPLIER = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INCREMENT  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MODULUS    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SEED       = 3'd3;

    // Sequencer states.
    typedef enum logic [1:0] {
        S_IDLE,
        S_MUL,
        S_DIV,
        S_DONE
    } t_fsm;

endpackage

// ----- design/lcg_keystream_xor_cipher.sv -----
// Top level of the LCG keystream XOR cipher: generator, divider and output stage.
// Depends on lkxc_pkg for widths, register indexes and the sequencer state type.
//
// Each request advances a 16-bit linear congruential generator, state =
// (multiplier * state + increment) mod modulus, and XORs the new state into the
// data word; the new state is also given out as the key word. After acceptance
// the product state forms the 32-bit product and sum, the divider state runs a
// radix-2 restoring remainder against the modulus register (one bit per cycle
// through a single shared subtractor), and the output state loads the output
// register. The input side stalls for that whole time and takes the next
// request once the sequencer returns to idle after the load, so it takes no new
// request before the last result is loaded. The output register lets a finished
// result wait while a new request is taken; if it is still full and stalled
// when the next result is ready, the load waits and the input stays stalled.
// A modulus of zero gives the low 16 bits of the sum unreduced.
// Configuration is written through a separate index/data port that is always
// ready and must only be used while the block is idle.
module lcg_keystream_xor_cipher
    import lkxc_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // Input requests
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic [WORD_W-1:0]    i_data_word,
    input  logic                 i_first_item,
    input  logic                 i_odd_byte,
    // Output results
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic [WORD_W-1:0]    o_cipher_word,
    output logic [WORD_W-1:0]    o_key_word,
    // Configuration writes
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [WORD_W-1:0]    i_cfg_data
);

    // Sequencer and control registers.
    t_fsm                  r_fsm, n_fsm;
    logic [STEP_CNT_W-1:0] r_cnt, n_cnt;
    logic                  r_out_valid, n_out_valid;

    // Configuration registers.
    logic [WORD_W-1:0] r_mul, r_inc, r_mod, r_seed;

    // Generator state and request payload.
    logic [WORD_W-1:0] r_gen;
    logic [WORD_W-1:0] r_data;
    logic              r_first;
    logic              r_odd;

    // Divider datapath.
    logic [PROD_W-1:0] r_dvd, n_dvd;
    logic [WORD_W-1:0] r_rem, n_rem;

    // Output register.
    logic [WORD_W-1:0] r_cipher, r_key;

    // Handshake decode.
    logic in_acc;
    logic out_free;
    logic load_out;

    // Shared arithmetic.
    logic [WORD_W-1:0] step_base;
    logic [PROD_W-1:0] prod_sum;
    logic [WORD_W:0]   rem_sh;
    logic [WORD_W:0]   rem_diff;
    logic              rem_ge;
    logic [WORD_W-1:0] cipher_val;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = (r_fsm != S_IDLE);
    assign in_acc      = i_in_valid && !o_in_stall;
    assign out_free    = !r_out_valid || !i_out_stall;

    // Product and sum; the largest value 0xFFFF0000 fits in 32 bits.
    assign step_base = r_first ? r_seed : r_gen;
    assign prod_sum  = r_mul * step_base + {{WORD_W{1'b0}}, r_inc};

    // One restoring step: shift a dividend bit in, subtract when it fits.
    // With a zero modulus every step subtracts nothing, which leaves the
    // low half of the sum in the remainder after all steps.
    assign rem_sh   = {r_rem, r_dvd[PROD_W-1]};
    assign rem_diff = rem_sh - {1'b0, r_mod};
    assign rem_ge   = (rem_sh >= {1'b0, r_mod});

    // Cipher word from the finished key.
    assign cipher_val = r_odd ? ((r_data ^ r_rem) & BYTE_MASK) : (r_data ^ r_rem);

    // Next state of the sequencer.
    always_comb begin
        n_fsm = r_fsm;
        unique case (r_fsm)
            S_IDLE: begin
                if (in_acc) n_fsm = S_MUL;
            end
            S_MUL: n_fsm = S_DIV;
            S_DIV: begin
                if (r_cnt == STEP_CNT_W'(DIV_STEPS - 1)) n_fsm = S_DONE;
            end
            S_DONE: begin
                if (out_free) n_fsm = S_IDLE;
            end
            default: n_fsm = S_IDLE;
        endcase
    end

    // Datapath and output controls of the sequencer.
    always_comb begin
        n_cnt       = r_cnt;
        n_dvd       = r_dvd;
        n_rem       = r_rem;
        load_out    = 1'b0;
        n_out_valid = r_out_valid && i_out_stall;
        unique case (r_fsm)
            S_IDLE: begin
                n_cnt = '0;
            end
            S_MUL: begin
                n_dvd = prod_sum;
                n_rem = '0;
                n_cnt = '0;
            end
            S_DIV: begin
                n_dvd = {r_dvd[PROD_W-2:0], 1'b0};
                n_rem = rem_ge ? rem_diff[WORD_W-1:0] : rem_sh[WORD_W-1:0];
                n_cnt = r_cnt + STEP_CNT_W'(1);
            end
            S_DONE: begin
                if (out_free) begin
                    load_out    = 1'b1;
                    n_out_valid = 1'b1;
                end
            end
            default: begin
                n_cnt = '0;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fsm       <= S_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_fsm       <= n_fsm;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    // Configuration registers and generator state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mul  <= '0;
            r_inc  <= '0;
            r_mod  <= WORD_W'(1);
            r_seed <= '0;
            r_gen  <= '0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                unique case (i_cfg_index)
                    CFG_MULTIPLIER: r_mul  <= i_cfg_data;
                    CFG_INCREMENT:  r_inc  <= i_cfg_data;
                    CFG_MODULUS:    r_mod  <= i_cfg_data;
                    CFG_SEED:       r_seed <= i_cfg_data;
                    default: ;
                endcase
            end
            if (load_out) r_gen <= r_rem;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_data  <= i_data_word;
            r_first <= i_first_item;
            r_odd   <= i_odd_byte;
        end
        r_dvd <= n_dvd;
        r_rem <= n_rem;
        if (load_out) begin
            r_cipher <= cipher_val;
            r_key    <= r_rem;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_cipher_word = r_cipher;
    assign o_key_word    = r_key;

    // An accepted request always starts with the product cycle.
    a_accept_to_mul: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> (r_fsm == S_MUL))
        else $error("accepted request did not enter the product cycle");

    // The partial remainder stays below a nonzero modulus.
    a_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_fsm == S_DIV) && (r_mod != '0)) |-> (r_rem < r_mod))
        else $error("partial remainder not below modulus");

    // The last divider step hands over to the output stage.
    a_div_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_fsm == S_DIV) && (r_cnt == STEP_CNT_W'(DIV_STEPS - 1))) |=> (r_fsm == S_DONE))
        else $error("divider did not finish after its last step");

    // A result only appears from the output stage.
    a_out_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> ($past(r_fsm) == S_DONE))
        else $error("result raised outside the output stage");

endmodule
